>>> rtl/modbus_rtu_response_checker_core_assert.svh
// Assertion macros shared by the response checker RTL
`ifndef MODBUS_RTU_RESPONSE_CHECKER_CORE_ASSERT_SVH
`define MODBUS_RTU_RESPONSE_CHECKER_CORE_ASSERT_SVH

// Same-cycle implication, disabled while in reset
`define MRC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset
`define MRC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/mrc_pkg.sv
// Types, constants and codes for the Modbus RTU response checker
package mrc_pkg;

    localparam int MAX_RETURNED_DEF = 8;

    localparam logic [7:0]  FC_READ   = 8'h03;
    localparam logic [7:0]  FC_WRITE  = 8'h06;
    localparam logic [15:0] CRC_INIT  = 16'hFFFF;
    localparam logic [15:0] CRC_POLY  = 16'hA001;
    localparam logic [8:0]  WRITE_LEN = 9'd8;
    localparam logic [8:0]  READ_OVERHEAD = 9'd5;
    localparam logic [6:0]  MAX_COUNT = 7'd125;
    localparam logic [3:0]  CRC_BITS  = 4'd8;

    // status codes
    localparam logic [1:0] STS_OK   = 2'd0;
    localparam logic [1:0] STS_FMT  = 2'd1;
    localparam logic [1:0] STS_CRC  = 2'd2;
    localparam logic [1:0] STS_LINK = 2'd3;

    // event kinds
    localparam logic [1:0] EVT_NONE   = 2'd0;
    localparam logic [1:0] EVT_ERROR  = 2'd1;
    localparam logic [1:0] EVT_SINGLE = 2'd2;
    localparam logic [1:0] EVT_MULTI  = 2'd3;

    typedef struct packed {
        logic       mode;
        logic [6:0] requested_count;
        logic [7:0] rx_byte;
        logic       link_error;
    } byte_item_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [1:0]  event_kind;
        logic [2:0]  register_index;
        logic [15:0] register_value;
        logic [6:0]  register_total;
        logic        last;
    } result_t;

    typedef struct packed {
        logic load;   // fold a new byte in, then shift it bit-serially
        logic fresh;  // byte opens a frame: start from the initial value
        logic clear;  // return the accumulator to its initial value
    } crc_ctl_t;

    typedef enum logic [2:0] {
        RES_LINK,
        RES_FMT,
        RES_CRC,
        RES_WRITE,
        RES_SINGLE,
        RES_ZERO,
        RES_MULTI
    } res_code_t;

endpackage

>>> rtl/mrc_crc.sv
// Bit-serial CRC-16 accumulator, one polynomial step per cycle
module mrc_crc
    import mrc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  crc_ctl_t    ctl,
    input  logic [7:0]  data,
    output logic [15:0] crc,
    output logic        busy
);

    logic [15:0] crc_reg;
    logic [15:0] crc_next;
    logic [3:0]  cnt_reg;
    logic [3:0]  cnt_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg <= CRC_INIT;
            cnt_reg <= '0;
        end
        else
        begin
            crc_reg <= crc_next;
            cnt_reg <= cnt_next;
        end
    end

    always_comb
    begin
        crc_next = crc_reg;
        cnt_next = cnt_reg;
        if (ctl.clear)
        begin
            crc_next = CRC_INIT;
        end
        else if (ctl.load)
        begin
            crc_next = (ctl.fresh ? CRC_INIT : crc_reg) ^ {8'h00, data};
            cnt_next = CRC_BITS;
        end
        else if (cnt_reg != '0)
        begin
            crc_next = crc_reg[0] ? ({1'b0, crc_reg[15:1]} ^ CRC_POLY)
                                  : {1'b0, crc_reg[15:1]};
            cnt_next = cnt_reg - 4'd1;
        end
    end

    assign crc  = crc_reg;
    assign busy = (cnt_reg != '0);

endmodule

>>> rtl/mrc_store.sv
// Register word store: one write port, one read port, registered read data
module mrc_store
    import mrc_pkg::*;
#(
    parameter int DEPTH  = MAX_RETURNED_DEF,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
)
(
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [15:0]       wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [15:0]       rdata
);

    logic [15:0] store_mem [DEPTH];
    logic [15:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            store_mem[waddr] <= wdata;
        end
        rd_data_reg <= store_mem[raddr];
    end

    assign rdata = rd_data_reg;

endmodule

>>> rtl/modbus_rtu_response_checker_core.sv
// Modbus RTU response checker: top level with frame sequencer and result output
// A frame byte that is covered by the CRC is folded into the bit-serial CRC shifter,
// and byte_stall is high while the shifter works on it. The two CRC bytes at the end
// of a frame do not go through the shifter. At frame end every result is a read of the
// register store, then a load into the output register, held back while rsp_stall
// holds the output register; the next byte is taken as soon as the last result sits in
// the output register. The store needs no clearing after reset.
`include "modbus_rtu_response_checker_core_assert.svh"

module modbus_rtu_response_checker_core
    import mrc_pkg::*;
#(
    parameter int MAX_RETURNED = MAX_RETURNED_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [7:0] cfg_data,
    input  logic       byte_valid,
    output logic       byte_stall,
    input  byte_item_t byte_data,
    output logic       rsp_valid,
    input  logic       rsp_stall,
    output result_t    rsp_data
);

    localparam int IDX_W = (MAX_RETURNED > 1) ? $clog2(MAX_RETURNED) : 1;
    localparam int CNT_W = $clog2(MAX_RETURNED + 1);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_RD   = 3'b010,
        ST_OUT  = 3'b100
    } state_t;

    state_t      state_reg, state_next;
    logic [7:0]  own_addr_reg;
    logic [7:0]  pos_reg, pos_next;
    logic        mode_reg, mode_next;
    logic [6:0]  count_reg, count_next;
    logic        hdr_reg, hdr_next;
    logic [7:0]  low_reg, low_next;
    logic [7:0]  hold_reg, hold_next;
    res_code_t   code_reg, code_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    logic [CNT_W-1:0] n_reg, n_next;
    logic        rsp_valid_reg, rsp_valid_next;
    result_t     rsp_data_reg, rsp_data_next;

    logic        accept;
    logic        crc_busy;
    logic [15:0] crc_val;
    crc_ctl_t    crc_ctl;
    logic        st_we;
    logic [IDX_W-1:0] st_waddr;
    logic [15:0] st_rdata;
    logic [15:0] st_wdata;

    logic        p_first;
    logic        mode_cur;
    logic [6:0]  count_cur;
    logic [6:0]  count_sat;
    logic [8:0]  len_cur;
    logic [8:0]  pos_plus2;
    logic [7:0]  off;
    logic        crc_ok;
    logic        out_free;
    logic        out_load;
    logic        res_last;
    logic [CNT_W-1:0] n_cur;

    assign cfg_ready  = 1'b1;
    assign byte_stall = (state_reg != ST_IDLE) || crc_busy;
    assign accept     = byte_valid && !byte_stall;
    assign out_free   = !rsp_valid_reg || !rsp_stall;
    assign out_load   = (state_reg == ST_OUT) && out_free;

    assign p_first   = (pos_reg == 8'd0);
    assign count_sat = (byte_data.requested_count > MAX_COUNT) ? MAX_COUNT
                                                               : byte_data.requested_count;
    assign mode_cur  = p_first ? byte_data.mode : mode_reg;
    assign count_cur = p_first ? count_sat : count_reg;
    assign len_cur   = mode_cur ? WRITE_LEN : (READ_OVERHEAD + {1'b0, count_cur, 1'b0});
    assign pos_plus2 = {1'b0, pos_reg} + 9'd2;
    assign off       = pos_reg - 8'd3;
    assign crc_ok    = (crc_val[7:0] == low_reg) && (crc_val[15:8] == byte_data.rx_byte);
    assign n_cur     = ({1'b0, count_reg} < 8'(MAX_RETURNED)) ? CNT_W'(count_reg)
                                                               : CNT_W'(MAX_RETURNED);
    assign st_wdata  = {hold_reg, byte_data.rx_byte};
    assign st_waddr  = off[IDX_W:1];
    assign res_last  = (code_reg != RES_MULTI) || (CNT_W'(idx_reg + CNT_W'(1)) == n_reg);

    mrc_crc u_crc (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (crc_ctl),
        .data  (byte_data.rx_byte),
        .crc   (crc_val),
        .busy  (crc_busy)
    );

    mrc_store #(
        .DEPTH  (MAX_RETURNED),
        .ADDR_W (IDX_W)
    ) u_store (
        .clk   (clk),
        .we    (st_we),
        .waddr (st_waddr),
        .wdata (st_wdata),
        .raddr (idx_reg[IDX_W-1:0]),
        .rdata (st_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            own_addr_reg  <= '0;
            pos_reg       <= '0;
            mode_reg      <= 1'b0;
            count_reg     <= '0;
            hdr_reg       <= 1'b1;
            low_reg       <= '0;
            hold_reg      <= '0;
            code_reg      <= RES_LINK;
            idx_reg       <= '0;
            n_reg         <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pos_reg       <= pos_next;
            mode_reg      <= mode_next;
            count_reg     <= count_next;
            hdr_reg       <= hdr_next;
            low_reg       <= low_next;
            hold_reg      <= hold_next;
            code_reg      <= code_next;
            idx_reg       <= idx_next;
            n_reg         <= n_next;
            rsp_valid_reg <= rsp_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                own_addr_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_data_reg <= rsp_data_next;
    end

    // byte decode and frame sequencing
    always_comb
    begin
        state_next = state_reg;
        pos_next   = pos_reg;
        mode_next  = mode_reg;
        count_next = count_reg;
        hdr_next   = hdr_reg;
        low_next   = low_reg;
        hold_next  = hold_reg;
        code_next  = code_reg;
        idx_next   = idx_reg;
        n_next     = n_reg;
        crc_ctl    = '0;
        st_we      = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (byte_data.link_error)
                    begin
                        pos_next      = '0;
                        hdr_next      = 1'b1;
                        crc_ctl.clear = 1'b1;
                        code_next     = RES_LINK;
                        idx_next      = '0;
                        state_next    = ST_RD;
                    end
                    else
                    begin
                        mode_next  = mode_cur;
                        count_next = count_cur;
                        if (p_first)
                        begin
                            hdr_next = (byte_data.rx_byte == own_addr_reg);
                        end
                        else if (pos_reg == 8'd1)
                        begin
                            if (byte_data.rx_byte != (mode_reg ? FC_WRITE : FC_READ))
                            begin
                                hdr_next = 1'b0;
                            end
                        end
                        else if ((pos_reg == 8'd2) && !mode_reg)
                        begin
                            if (byte_data.rx_byte[7:1] != count_reg)
                            begin
                                hdr_next = 1'b0;
                            end
                        end

                        priority if (pos_plus2 < len_cur)
                        begin
                            crc_ctl.load  = 1'b1;
                            crc_ctl.fresh = p_first;
                            if (!mode_cur && (pos_reg >= 8'd3))
                            begin
                                if (!off[0])
                                begin
                                    hold_next = byte_data.rx_byte;
                                end
                                else if ({1'b0, off[7:1]} < 8'(MAX_RETURNED))
                                begin
                                    st_we = 1'b1;
                                end
                            end
                            pos_next = pos_reg + 8'd1;
                        end
                        else if (pos_plus2 == len_cur)
                        begin
                            low_next = byte_data.rx_byte;
                            pos_next = pos_reg + 8'd1;
                        end
                        else
                        begin
                            // closing byte: decide the outcome
                            pos_next      = '0;
                            hdr_next      = 1'b1;
                            crc_ctl.clear = 1'b1;
                            idx_next      = '0;
                            n_next        = n_cur;
                            state_next    = ST_RD;
                            priority if (!hdr_reg)
                                code_next = RES_FMT;
                            else if (!crc_ok)
                                code_next = RES_CRC;
                            else if (mode_reg)
                                code_next = RES_WRITE;
                            else if (count_reg == 7'd1)
                                code_next = RES_SINGLE;
                            else if (n_cur == '0)
                                code_next = RES_ZERO;
                            else
                                code_next = RES_MULTI;
                        end
                    end
                end
            end
            ST_RD:
            begin
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    if (res_last)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        idx_next   = CNT_W'(idx_reg + CNT_W'(1));
                        state_next = ST_RD;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // result formatting into the output register
    always_comb
    begin
        rsp_data_next  = rsp_data_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        if (out_load)
        begin
            rsp_valid_next = 1'b1;
            rsp_data_next  = '0;
            rsp_data_next.last = res_last;
            unique case (code_reg)
                RES_LINK:
                begin
                    rsp_data_next.status     = STS_LINK;
                    rsp_data_next.event_kind = EVT_ERROR;
                end
                RES_FMT:
                begin
                    rsp_data_next.status = STS_FMT;
                end
                RES_CRC:
                begin
                    rsp_data_next.status = STS_CRC;
                end
                RES_WRITE:
                begin
                    rsp_data_next.status = STS_OK;
                end
                RES_SINGLE:
                begin
                    rsp_data_next.event_kind     = EVT_SINGLE;
                    rsp_data_next.register_value = st_rdata;
                    rsp_data_next.register_total = 7'd1;
                end
                RES_ZERO:
                begin
                    rsp_data_next.event_kind = EVT_MULTI;
                end
                RES_MULTI:
                begin
                    rsp_data_next.event_kind     = EVT_MULTI;
                    rsp_data_next.register_index = 3'(idx_reg);
                    rsp_data_next.register_value = st_rdata;
                    rsp_data_next.register_total = count_reg;
                end
                default:
                begin
                    rsp_data_next.status = STS_OK;
                end
            endcase
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_data_reg;

    `MRC_ASSERT_NOW(a_crc_only_idle, clk, rst_n, crc_busy, state_reg == ST_IDLE,
        "CRC shifter busy while results are being sent")
    `MRC_ASSERT_NOW(a_pos_in_frame, clk, rst_n, pos_reg != 8'd0,
        {1'b0, pos_reg} < (mode_reg ? WRITE_LEN : (READ_OVERHEAD + {1'b0, count_reg, 1'b0})),
        "byte position beyond frame length")
    `MRC_ASSERT_NOW(a_idx_bound, clk, rst_n,
        (state_reg != ST_IDLE) && (code_reg == RES_MULTI), idx_reg < n_reg,
        "result index beyond returned register count")
    `MRC_ASSERT_NEXT(a_last_ends, clk, rst_n, out_load && res_last, state_reg == ST_IDLE,
        "sequencer did not return to idle after the final result")

endmodule
